/* design/hash_seeded_unit_vector_assert.svh */
// ---------------------------------------------------------------------------
// hash_seeded_unit_vector assertion macros
// shared concurrent check forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef HASH_SEEDED_UNIT_VECTOR_ASSERT_SVH
`define HASH_SEEDED_UNIT_VECTOR_ASSERT_SVH

// consequent holds in the same cycle
`define HSUV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the following cycle
`define HSUV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/hsuv_pkg.sv */
// ---------------------------------------------------------------------------
// hsuv_pkg
// types, constants and command codes of the seeded unit vector block
// ---------------------------------------------------------------------------
package hsuv_pkg;

    localparam int DEF_MAX_DIMS    = 64;
    localparam int DEF_SAMPLE_BITS = 24;

    localparam int DIMS_W    = 7;
    localparam int COMP_W    = 18;
    localparam int IDX_OUT_W = 6;
    localparam int FRAC_W    = 16;
    localparam int Q_W       = 18;

    localparam logic [63:0] FNV_BASIS    = 64'hCBF29CE484222325;
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;   // prime is 2^40 + this
    localparam int          FNV_SHIFT    = 40;
    localparam logic [63:0] LCG_MUL      = 64'h5851F42D4C957F2D;
    localparam logic [63:0] LCG_ADD      = 64'h14057B7EF767814F;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE = 4'd0;
    localparam logic [OP_W-1:0] OP_HASH = 4'd1;
    localparam logic [OP_W-1:0] OP_SEED = 4'd2;
    localparam logic [OP_W-1:0] OP_G0   = 4'd3;
    localparam logic [OP_W-1:0] OP_G1   = 4'd4;
    localparam logic [OP_W-1:0] OP_G2   = 4'd5;
    localparam logic [OP_W-1:0] OP_G3   = 4'd6;
    localparam logic [OP_W-1:0] OP_G4   = 4'd7;
    localparam logic [OP_W-1:0] OP_G5   = 4'd8;
    localparam logic [OP_W-1:0] OP_G6   = 4'd9;
    localparam logic [OP_W-1:0] OP_SQI  = 4'd10;
    localparam logic [OP_W-1:0] OP_SQ   = 4'd11;
    localparam logic [OP_W-1:0] OP_RD   = 4'd12;
    localparam logic [OP_W-1:0] OP_DVI  = 4'd13;
    localparam logic [OP_W-1:0] OP_DV   = 4'd14;
    localparam logic [OP_W-1:0] OP_EMIT = 4'd15;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       byte_present;
        logic       text_end;
    } hsuv_item_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] component;
        logic [IDX_OUT_W-1:0]     component_index;
        logic                     vector_end;
    } hsuv_result_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            last;
    } hsuv_cmd_t;

endpackage

/* design/hsuv_ram.sv */
// ---------------------------------------------------------------------------
// hsuv_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module hsuv_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/hsuv_ctrl.sv */
// ---------------------------------------------------------------------------
// hsuv_ctrl
// sequencer: text intake, generator steps, root iterations, division passes
// ---------------------------------------------------------------------------
module hsuv_ctrl #(
    parameter int MAX_DIMS    = hsuv_pkg::DEF_MAX_DIMS,
    parameter int SAMPLE_BITS = hsuv_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic                                   text_end,
    input  logic                                   cfg_valid,
    input  logic [hsuv_pkg::DIMS_W-1:0]            cfg_data,
    output logic                                   busy,
    output hsuv_pkg::hsuv_cmd_t                    cmd,
    output logic [$clog2(MAX_DIMS+1)-1:0]          idx
);
    import hsuv_pkg::*;

    localparam int CNT_W    = $clog2(MAX_DIMS + 1);
    localparam int ROOT_W   = (2 * SAMPLE_BITS + 6) / 2;
    localparam int STEP_MAX = (ROOT_W > Q_W) ? ROOT_W : Q_W;
    localparam int STEP_W   = $clog2(STEP_MAX + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SEED = 4'd1;
    localparam logic [3:0] S_G0   = 4'd2;
    localparam logic [3:0] S_G1   = 4'd3;
    localparam logic [3:0] S_G2   = 4'd4;
    localparam logic [3:0] S_G3   = 4'd5;
    localparam logic [3:0] S_G4   = 4'd6;
    localparam logic [3:0] S_G5   = 4'd7;
    localparam logic [3:0] S_G6   = 4'd8;
    localparam logic [3:0] S_SQI  = 4'd9;
    localparam logic [3:0] S_SQ   = 4'd10;
    localparam logic [3:0] S_RD   = 4'd11;
    localparam logic [3:0] S_DVI  = 4'd12;
    localparam logic [3:0] S_DV   = 4'd13;
    localparam logic [3:0] S_EMIT = 4'd14;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  dims_reg, dims_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DIMS_W-1:0] cfg_dims_reg;
    logic [CNT_W-1:0]  dims_eff;
    logic              at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_dims_reg <= DIMS_W'(DEF_MAX_DIMS);
        end
        else if (cfg_valid)
        begin
            cfg_dims_reg <= cfg_data;
        end
    end

    // zero acts as one, too large saturates
    always_comb
    begin
        if (cfg_dims_reg == '0)
        begin
            dims_eff = CNT_W'(1);
        end
        else if (32'(cfg_dims_reg) > MAX_DIMS)
        begin
            dims_eff = CNT_W'(MAX_DIMS);
        end
        else
        begin
            dims_eff = CNT_W'(cfg_dims_reg);
        end
    end

    assign at_last = (idx_reg + CNT_W'(1)) == dims_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        dims_next  = dims_reg;
        step_next  = step_reg;
        cmd.op     = OP_NONE;
        cmd.last   = at_last;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = OP_HASH;
                    if (text_end)
                    begin
                        state_next = S_SEED;
                    end
                end
            end
            S_SEED:
            begin
                cmd.op     = OP_SEED;
                idx_next   = '0;
                dims_next  = dims_eff;
                state_next = S_G0;
            end
            S_G0:
            begin
                cmd.op     = OP_G0;
                state_next = S_G1;
            end
            S_G1:
            begin
                cmd.op     = OP_G1;
                state_next = S_G2;
            end
            S_G2:
            begin
                cmd.op     = OP_G2;
                state_next = S_G3;
            end
            S_G3:
            begin
                cmd.op     = OP_G3;
                state_next = S_G4;
            end
            S_G4:
            begin
                cmd.op     = OP_G4;
                state_next = S_G5;
            end
            S_G5:
            begin
                cmd.op     = OP_G5;
                state_next = S_G6;
            end
            S_G6:
            begin
                cmd.op = OP_G6;
                if (at_last)
                begin
                    idx_next   = '0;
                    state_next = S_SQI;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_G0;
                end
            end
            S_SQI:
            begin
                cmd.op     = OP_SQI;
                step_next  = '0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.op    = OP_SQ;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ROOT_W - 1))
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.op     = OP_RD;
                state_next = S_DVI;
            end
            S_DVI:
            begin
                cmd.op     = OP_DVI;
                step_next  = '0;
                state_next = S_DV;
            end
            S_DV:
            begin
                cmd.op    = OP_DV;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(Q_W - 1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.op = OP_EMIT;
                if (at_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            dims_reg  <= CNT_W'(1);
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            dims_reg  <= dims_next;
            step_reg  <= step_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign idx  = idx_reg;

endmodule

/* design/hsuv_dp.sv */
// ---------------------------------------------------------------------------
// hsuv_dp
// datapath: hash, generator multiply, sum of squares, root and divider
// ---------------------------------------------------------------------------
module hsuv_dp #(
    parameter int MAX_DIMS    = hsuv_pkg::DEF_MAX_DIMS,
    parameter int SAMPLE_BITS = hsuv_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hsuv_pkg::hsuv_item_t          item,
    input  hsuv_pkg::hsuv_cmd_t           cmd,
    input  logic [$clog2(MAX_DIMS+1)-1:0] idx,
    output hsuv_pkg::hsuv_result_t        result,
    output logic                          done
);
    import hsuv_pkg::*;

    localparam int CNT_W  = $clog2(MAX_DIMS + 1);
    localparam int A_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int SUM_W  = 2 * SAMPLE_BITS + 5;
    localparam int ROOT_W = (SUM_W + 1) / 2;
    localparam int SQ_W   = 2 * ROOT_W;
    localparam int NUM_W  = SAMPLE_BITS + 18;

    logic [63:0]             hash_reg, gen_reg, acc_reg, prod_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [SQ_W-1:0]         sv_reg;
    logic [ROOT_W:0]         rem_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic [Q_W-1:0]          nlo_reg, q_reg;
    logic                    neg_reg;
    hsuv_result_t            result_reg;
    logic                    done_reg;

    logic [63:0]             hash_x;
    logic [31:0]             mul_a, mul_b;
    logic [SAMPLE_BITS-1:0]  sample, mag, rd_sample, rd_mag;
    logic [SAMPLE_BITS-1:0]  rdata;
    logic [ROOT_W+2:0]       sq_trial, sq_test;
    logic                    sq_take;
    logic [NUM_W-1:0]        num;
    logic [ROOT_W+1:0]       dv_trial, dv_den;
    logic                    dv_take;
    logic [COMP_W-1:0]       q_ext;

    assign hash_x = hash_reg ^ {56'd0, item.text_byte};

    assign sample = gen_reg[63 -: SAMPLE_BITS];
    assign mag    = sample[SAMPLE_BITS-1] ? (~sample + SAMPLE_BITS'(1)) : sample;

    // single 32x32 multiplier shared by generator and squaring steps
    always_comb
    begin
        mul_a = 32'(mag);
        mul_b = 32'(mag);
        unique case (cmd.op)
            OP_G0:
            begin
                mul_a = gen_reg[31:0];
                mul_b = LCG_MUL[31:0];
            end
            OP_G1:
            begin
                mul_a = gen_reg[31:0];
                mul_b = LCG_MUL[63:32];
            end
            OP_G2:
            begin
                mul_a = gen_reg[63:32];
                mul_b = LCG_MUL[31:0];
            end
            default:
            begin
                mul_a = 32'(mag);
                mul_b = 32'(mag);
            end
        endcase
    end

    // root: two radicand bits per step
    assign sq_trial = {rem_reg, sv_reg[SQ_W-1 -: 2]};
    assign sq_test  = {1'b0, root_reg, 2'b01};
    assign sq_take  = sq_trial >= sq_test;

    // divider: round(mag * 2^16 / norm) as floor((mag * 2^17 + norm) / (2 * norm))
    assign rd_sample = rdata;
    assign rd_mag    = rd_sample[SAMPLE_BITS-1] ? (~rd_sample + SAMPLE_BITS'(1)) : rd_sample;
    assign num       = (NUM_W'(rd_mag) << (FRAC_W + 1)) + NUM_W'(root_reg);
    assign dv_trial  = {rem_reg, nlo_reg[Q_W-1]};
    assign dv_den    = {1'b0, root_reg, 1'b0};
    assign dv_take   = dv_trial >= dv_den;
    assign q_ext     = COMP_W'(q_reg);

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        unique case (cmd.op)
            OP_SEED:
            begin
                gen_reg <= hash_reg;
                sum_reg <= '0;
            end
            OP_G1:
            begin
                acc_reg <= prod_reg;
            end
            OP_G2, OP_G3:
            begin
                acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
            end
            OP_G4:
            begin
                gen_reg <= acc_reg + LCG_ADD;
            end
            OP_G6:
            begin
                sum_reg <= sum_reg + SUM_W'(prod_reg);
            end
            OP_SQI:
            begin
                sv_reg   <= SQ_W'(sum_reg);
                rem_reg  <= '0;
                root_reg <= '0;
            end
            OP_SQ:
            begin
                sv_reg <= sv_reg << 2;
                if (sq_take)
                begin
                    rem_reg  <= (ROOT_W+1)'(sq_trial - sq_test);
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= (ROOT_W+1)'(sq_trial);
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            OP_DVI:
            begin
                neg_reg <= rd_sample[SAMPLE_BITS-1];
                rem_reg <= (ROOT_W+1)'(num[NUM_W-1:Q_W]);
                nlo_reg <= num[Q_W-1:0];
                q_reg   <= '0;
            end
            OP_DV:
            begin
                nlo_reg <= nlo_reg << 1;
                q_reg   <= {q_reg[Q_W-2:0], dv_take};
                rem_reg <= dv_take ? (ROOT_W+1)'(dv_trial - dv_den)
                                   : (ROOT_W+1)'(dv_trial);
            end
            OP_EMIT:
            begin
                if (root_reg == '0)
                begin
                    result_reg.component <= '0;
                end
                else
                begin
                    result_reg.component <= neg_reg ? -q_ext : q_ext;
                end
                result_reg.component_index <= IDX_OUT_W'(idx);
                result_reg.vector_end      <= cmd.last;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= FNV_BASIS;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.op == OP_EMIT);
            if (cmd.op == OP_SEED)
            begin
                hash_reg <= FNV_BASIS;
            end
            else if (cmd.op == OP_HASH && item.byte_present)
            begin
                hash_reg <= (hash_x << FNV_SHIFT) + hash_x * 64'(FNV_PRIME_LO);
            end
        end
    end

    hsuv_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_DIMS)
    ) u_samples (
        .clk   (clk),
        .we    (cmd.op == OP_G5),
        .waddr (idx[A_W-1:0]),
        .wdata (sample),
        .re    (cmd.op == OP_RD),
        .raddr (idx[A_W-1:0]),
        .rdata (rdata)
    );

    assign result = result_reg;
    assign done   = done_reg;

endmodule

/* design/hash_seeded_unit_vector.sv */
// ---------------------------------------------------------------------------
// hash_seeded_unit_vector
// text hash seeded pseudo random vector, normalized to unit length
// ---------------------------------------------------------------------------
// A byte word is taken on start while busy is low; a word without
// text_end leaves busy low. A word with text_end starts the vector:
// per component, generator stepping G0 to G6 on the shared 32x32
// multiplier, then the square root of the sum of squares, then per
// component a sample read and the 18-step divider. Each result shows
// on result for one cycle with done high; the receiver cannot stall,
// so it must take every one.
module hash_seeded_unit_vector #(
    parameter int MAX_DIMS    = hsuv_pkg::DEF_MAX_DIMS,
    parameter int SAMPLE_BITS = hsuv_pkg::DEF_SAMPLE_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  hsuv_pkg::hsuv_item_t         item,
    output logic                         done,
    output hsuv_pkg::hsuv_result_t       result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [hsuv_pkg::DIMS_W-1:0]  cfg_data
);
    import hsuv_pkg::*;

    `include "hash_seeded_unit_vector_assert.svh"

    localparam int CNT_W = $clog2(MAX_DIMS + 1);

    hsuv_cmd_t        cmd;
    logic [CNT_W-1:0] idx;

    assign cfg_ready = 1'b1;

    hsuv_ctrl #(
        .MAX_DIMS    (MAX_DIMS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .text_end  (item.text_end),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .cmd       (cmd),
        .idx       (idx)
    );

    hsuv_dp #(
        .MAX_DIMS    (MAX_DIMS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .idx    (idx),
        .result (result),
        .done   (done)
    );

    `HSUV_ASSERT_NOW(a_done_while_busy, done, $past(busy), "word emitted outside a vector")
    `HSUV_ASSERT_NOW(a_end_frees, done && result.vector_end, !busy, "busy after vector end")
    `HSUV_ASSERT_NEXT(a_plain_byte_idle, start && !busy && !item.text_end, !busy,
        "byte word without end left block busy")
    `HSUV_ASSERT_NOW(a_unit_range, done,
        ($signed(result.component) <= 18'sd65536) && ($signed(result.component) >= -18'sd65536),
        "component out of unit range")

endmodule
